### rtl/mfp_pkg.sv
// Package for the meter frame parser: parser phase type, result kinds,
// error codes, register indexes and register reset values.
// No dependencies.
package mfp_pkg;

   // Parser phase: one per field of the frame layout, plus ST_SKIP for the rest of a buffer.
   typedef enum logic [3:0] {
      ST_SEEK   = 4'd0,
      ST_ADDR   = 4'd1,
      ST_START2 = 4'd2,
      ST_CTRL   = 4'd3,
      ST_LEN    = 4'd4,
      ST_DATA   = 4'd5,
      ST_CSUM   = 4'd6,
      ST_END    = 4'd7,
      ST_SKIP   = 4'd8
   } phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   // Verdict error codes.
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_NO_START  = 3'd1;
   localparam logic [2:0] ERR_START2    = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED = 3'd3;
   localparam logic [2:0] ERR_CHECKSUM  = 3'd4;
   localparam logic [2:0] ERR_END       = 3'd5;

   // Register indexes (byte address divided by four).
   localparam logic [1:0] REG_START_MARKER = 2'd0;
   localparam logic [1:0] REG_END_MARKER   = 2'd1;
   localparam logic [1:0] REG_DATA_OFFSET  = 2'd2;

   // Register reset values.
   localparam logic [7:0] START_MARKER_RESET = 8'h68;
   localparam logic [7:0] END_MARKER_RESET   = 8'h16;
   localparam logic [7:0] DATA_OFFSET_RESET  = 8'h33;

   // Number of address bytes in a frame.
   localparam logic [2:0] ADDR_BYTES = 3'd6;

endpackage

### rtl/meter_frame_parser.sv
// Meter frame parser top level: byte stream in, decoded data bytes and
// frame verdicts out, with an APB-style register port.
// Depends on mfp_pkg.
//
// Channel   Direction  Transaction
// req_      in         one received byte; tlast marks the last byte of a buffer
// rsp_      out        one data byte or one frame verdict; tuser holds the kind
// csr_      in/out     register write or read, three 8-bit registers
//
// The parser state and the result register are updated at the edge that
// accepts the byte, so a byte can enter every cycle while req_tready is high.
// The result register is the only buffer; req_tready drops only while a
// result is held and rsp_tready is low. Reset is synchronous and active high
// and clears the phase, the frame fields and the registers to their defaults.
module meter_frame_parser (
   input  logic        clock,
   input  logic        reset,
   // Byte stream.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,   // buffer_last
   // Results.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] data_byte, [55:8] meter_address, [63:56] control_code,
   // [71:64] payload_length, [74:72] error_code, [79:75] zero
   output logic [79:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   // Register port.
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mfp_pkg::*;

   // Configuration registers.
   logic [7:0] start_marker_ff;
   logic [7:0] end_marker_ff;
   logic [7:0] data_offset_ff;

   // Parser state.
   phase_type  phase_ff, phase_in;
   logic [7:0] field_count_ff, field_count_in;
   logic [7:0] sum_acc_ff, sum_acc_in;
   logic [47:0] addr_ff, addr_in;
   logic [7:0] ctrl_ff, ctrl_in;
   logic [7:0] len_ff, len_in;
   logic       sum_bad_ff, sum_bad_in;

   // Result register.
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  data_byte_ff, data_byte_in;
   logic [47:0] out_addr_ff, out_addr_in;
   logic [7:0]  out_ctrl_ff, out_ctrl_in;
   logic [7:0]  out_len_ff, out_len_in;
   logic [2:0]  err_ff, err_in;

   logic       req_accept;
   logic       csr_write;
   logic       emit;
   logic       verdict;
   logic [2:0] verdict_err;
   logic [7:0] b;
   logic       last;
   logic [7:0] count_inc;

   assign b         = req_tdata;
   assign last      = req_tlast;
   assign count_inc = field_count_ff + 8'd1;

   // A byte is taken whenever the result register is free or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   // Register port: writes in the access phase, reads return the value.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[3:2])
         REG_START_MARKER: csr_prdata = {24'd0, start_marker_ff};
         REG_END_MARKER:   csr_prdata = {24'd0, end_marker_ff};
         REG_DATA_OFFSET:  csr_prdata = {24'd0, data_offset_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_marker_ff <= START_MARKER_RESET;
         end_marker_ff   <= END_MARKER_RESET;
         data_offset_ff  <= DATA_OFFSET_RESET;
      end else if (csr_write) begin
         case (csr_paddr[3:2])
            REG_START_MARKER: start_marker_ff <= csr_pwdata[7:0];
            REG_END_MARKER:   end_marker_ff   <= csr_pwdata[7:0];
            REG_DATA_OFFSET:  data_offset_ff  <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Frame parser: next state and the result for the current byte.
   always_comb begin
      phase_in       = phase_ff;
      field_count_in = field_count_ff;
      sum_acc_in     = sum_acc_ff;
      addr_in        = addr_ff;
      ctrl_in        = ctrl_ff;
      len_in         = len_ff;
      sum_bad_in     = sum_bad_ff;
      emit           = 1'b0;
      verdict        = 1'b0;
      verdict_err    = ERR_NONE;
      kind_in        = KIND_DATA;
      data_byte_in   = 8'd0;
      out_addr_in    = 48'd0;
      out_ctrl_in    = 8'd0;
      out_len_in     = 8'd0;
      err_in         = ERR_NONE;

      case (phase_ff)
         ST_SEEK: begin
            if (b != start_marker_ff) begin
               verdict     = last;
               verdict_err = ERR_NO_START;
            end else begin
               field_count_in = 8'd0;
               addr_in        = 48'd0;
               ctrl_in        = 8'd0;
               len_in         = 8'd0;
               sum_bad_in     = 1'b0;
               sum_acc_in     = b;
               phase_in       = ST_ADDR;
               verdict        = last;
               verdict_err    = ERR_TRUNCATED;
            end
         end
         ST_ADDR: begin
            // Address bytes shift in from the top, so the first lands lowest.
            addr_in    = {b, addr_ff[47:8]};
            sum_acc_in = sum_acc_ff + b;
            if (count_inc >= {5'd0, ADDR_BYTES}) begin
               field_count_in = 8'd0;
               phase_in       = ST_START2;
            end else begin
               field_count_in = count_inc;
            end
            verdict     = last;
            verdict_err = ERR_TRUNCATED;
         end
         ST_START2: begin
            if (b != start_marker_ff) begin
               verdict     = 1'b1;
               verdict_err = ERR_START2;
            end else begin
               sum_acc_in  = sum_acc_ff + b;
               phase_in    = ST_CTRL;
               verdict     = last;
               verdict_err = ERR_TRUNCATED;
            end
         end
         ST_CTRL: begin
            ctrl_in     = b;
            sum_acc_in  = sum_acc_ff + b;
            phase_in    = ST_LEN;
            verdict     = last;
            verdict_err = ERR_TRUNCATED;
         end
         ST_LEN: begin
            len_in         = b;
            sum_acc_in     = sum_acc_ff + b;
            field_count_in = 8'd0;
            phase_in       = (b == 8'd0) ? ST_CSUM : ST_DATA;
            verdict        = last;
            verdict_err    = ERR_TRUNCATED;
         end
         ST_DATA: begin
            if (last) begin
               verdict     = 1'b1;
               verdict_err = ERR_TRUNCATED;
            end else begin
               sum_acc_in     = sum_acc_ff + b;
               field_count_in = count_inc;
               if (count_inc >= len_ff) begin
                  phase_in = ST_CSUM;
               end
               emit         = 1'b1;
               kind_in      = KIND_DATA;
               data_byte_in = b - data_offset_ff;
            end
         end
         ST_CSUM: begin
            if (last) begin
               verdict     = 1'b1;
               verdict_err = ERR_TRUNCATED;
            end else begin
               sum_bad_in = (b != sum_acc_ff);
               phase_in   = ST_END;
            end
         end
         ST_END: begin
            verdict = 1'b1;
            if (sum_bad_ff) begin
               verdict_err = ERR_CHECKSUM;
            end else if (b != end_marker_ff) begin
               verdict_err = ERR_END;
            end else begin
               verdict_err = ERR_NONE;
            end
         end
         ST_SKIP: begin
            if (last) begin
               field_count_in = 8'd0;
               sum_acc_in     = 8'd0;
               addr_in        = 48'd0;
               ctrl_in        = 8'd0;
               len_in         = 8'd0;
               sum_bad_in     = 1'b0;
               phase_in       = ST_SEEK;
            end
         end
         default: begin
            phase_in = ST_SEEK;
         end
      endcase

      // A verdict closes the frame and clears the frame fields.
      if (verdict) begin
         emit = 1'b1;
         if (verdict_err == ERR_NONE) begin
            kind_in     = KIND_ACCEPT;
            out_addr_in = addr_ff;
            out_ctrl_in = ctrl_ff;
            out_len_in  = len_ff;
         end else begin
            kind_in = KIND_REJECT;
            err_in  = verdict_err;
         end
         data_byte_in   = 8'd0;
         field_count_in = 8'd0;
         sum_acc_in     = 8'd0;
         addr_in        = 48'd0;
         ctrl_in        = 8'd0;
         len_in         = 8'd0;
         sum_bad_in     = 1'b0;
         phase_in       = last ? ST_SEEK : ST_SKIP;
      end
   end

   // Result valid: loaded on each accepted byte, cleared once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = emit;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Parser state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= ST_SEEK;
         field_count_ff <= 8'd0;
         sum_acc_ff     <= 8'd0;
         addr_ff        <= 48'd0;
         ctrl_ff        <= 8'd0;
         len_ff         <= 8'd0;
         sum_bad_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff       <= phase_in;
            field_count_ff <= field_count_in;
            sum_acc_ff     <= sum_acc_in;
            addr_ff        <= addr_in;
            ctrl_ff        <= ctrl_in;
            len_ff         <= len_in;
            sum_bad_ff     <= sum_bad_in;
         end
      end
   end

   // Result payload, loaded when a byte produces a result.
   always_ff @(posedge clock) begin
      if (req_accept && emit) begin
         kind_ff      <= kind_in;
         data_byte_ff <= data_byte_in;
         out_addr_ff  <= out_addr_in;
         out_ctrl_ff  <= out_ctrl_in;
         out_len_ff   <= out_len_in;
         err_ff       <= err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {5'd0, err_ff, out_len_ff, out_ctrl_ff, out_addr_ff, data_byte_ff};

endmodule

### tb/meter_frame_parser_tb.sv
// Self-checking testbench for meter_frame_parser. It streams framed byte
// buffers through the parser and checks every data byte and verdict.
// Depends on mfp_pkg and the meter_frame_parser RTL.
import mfp_pkg::*;

// One parser result, unpacked from rsp_tdata and rsp_tuser.
typedef struct {
   logic [1:0]  kind;
   logic [7:0]  data_byte;
   logic [47:0] meter_address;
   logic [7:0]  control_code;
   logic [7:0]  payload_length;
   logic [2:0]  error_code;
} parse_result_type;

// Tracks the parser state from the accepted bytes, queues the results they
// cause and checks the results that come out of the block.
class frame_scoreboard;
   logic [7:0]       start_marker = START_MARKER_RESET;
   logic [7:0]       end_marker   = END_MARKER_RESET;
   logic [7:0]       data_offset  = DATA_OFFSET_RESET;
   phase_type        phase        = ST_SEEK;
   logic [7:0]       field_count  = 8'h00;
   logic [7:0]       sum_acc      = 8'h00;
   logic [47:0]      addr_reg     = 48'h0;
   logic [7:0]       ctrl_reg     = 8'h00;
   logic [7:0]       len_reg      = 8'h00;
   logic             sum_bad      = 1'b0;
   parse_result_type expected_results[$];
   int               mismatches   = 0;
   int               bytes_seen   = 0;
   int               data_seen    = 0;
   int               accepts_seen = 0;
   int               rejects_seen = 0;

   function void set_register(logic [1:0] index, logic [7:0] value);
      case (index)
         REG_START_MARKER: start_marker = value;
         REG_END_MARKER:   end_marker   = value;
         REG_DATA_OFFSET:  data_offset  = value;
         default: ;
      endcase
   endfunction

   function void clear_frame();
      field_count = 8'h00;
      sum_acc     = 8'h00;
      addr_reg    = 48'h0;
      ctrl_reg    = 8'h00;
      len_reg     = 8'h00;
      sum_bad     = 1'b0;
   endfunction

   // Counts a mismatch and tells whether it is still among those reported.
   function bit count_mismatch();
      mismatches++;
      return mismatches <= 10;
   endfunction

   // Adds one expected result at the tail of the queue.
   function void queue_result(parse_result_type r);
      expected_results.insert(expected_results.size(), r);
   endfunction

   // Queues the verdict that closes a frame; the rest of the buffer is skipped.
   function void push_verdict(logic last, logic [2:0] err);
      parse_result_type r;
      r = '{default: '0};
      if (err == ERR_NONE) begin
         r.kind           = KIND_ACCEPT;
         r.meter_address  = addr_reg;
         r.control_code   = ctrl_reg;
         r.payload_length = len_reg;
      end else begin
         r.kind       = KIND_REJECT;
         r.error_code = err;
      end
      queue_result(r);
      clear_frame();
      phase = last ? ST_SEEK : ST_SKIP;
   endfunction

   // Advances the frame state by one accepted byte.
   function void note_byte(logic [7:0] b, logic last);
      parse_result_type r;
      bytes_seen++;
      case (phase)
         ST_SEEK: begin
            if (b != start_marker) begin
               if (last) push_verdict(last, ERR_NO_START);
            end else begin
               clear_frame();
               sum_acc = b;
               phase   = ST_ADDR;
               if (last) push_verdict(last, ERR_TRUNCATED);
            end
         end
         ST_ADDR: begin
            addr_reg = addr_reg | (48'(b) << (8 * field_count));
            sum_acc  = sum_acc + b;
            field_count++;
            if (field_count >= 8'(ADDR_BYTES)) begin
               field_count = 8'h00;
               phase       = ST_START2;
            end
            if (last) push_verdict(last, ERR_TRUNCATED);
         end
         ST_START2: begin
            if (b != start_marker) begin
               push_verdict(last, ERR_START2);
            end else begin
               sum_acc = sum_acc + b;
               phase   = ST_CTRL;
               if (last) push_verdict(last, ERR_TRUNCATED);
            end
         end
         ST_CTRL: begin
            ctrl_reg = b;
            sum_acc  = sum_acc + b;
            phase    = ST_LEN;
            if (last) push_verdict(last, ERR_TRUNCATED);
         end
         ST_LEN: begin
            len_reg     = b;
            sum_acc     = sum_acc + b;
            field_count = 8'h00;
            phase       = (b == 8'h00) ? ST_CSUM : ST_DATA;
            if (last) push_verdict(last, ERR_TRUNCATED);
         end
         ST_DATA: begin
            // A data byte that ends the buffer is replaced by the reject.
            if (last) begin
               push_verdict(last, ERR_TRUNCATED);
            end else begin
               sum_acc = sum_acc + b;
               field_count++;
               if (field_count >= len_reg) phase = ST_CSUM;
               r = '{default: '0};
               r.kind      = KIND_DATA;
               r.data_byte = b - data_offset;
               queue_result(r);
            end
         end
         ST_CSUM: begin
            // The checksum verdict waits for the byte after the checksum.
            if (last) begin
               push_verdict(last, ERR_TRUNCATED);
            end else begin
               sum_bad = (b != sum_acc);
               phase   = ST_END;
            end
         end
         ST_END: begin
            if (sum_bad)
               push_verdict(last, ERR_CHECKSUM);
            else if (b != end_marker)
               push_verdict(last, ERR_END);
            else
               push_verdict(last, ERR_NONE);
         end
         default: begin
            if (last) begin
               clear_frame();
               phase = ST_SEEK;
            end
         end
      endcase
   endfunction

   // Compares one result transaction with the oldest queued expectation.
   function void check_result(logic [79:0] tdata, logic [1:0] tuser);
      parse_result_type got, want;
      got.kind           = tuser;
      got.data_byte      = tdata[7:0];
      got.meter_address  = tdata[55:8];
      got.control_code   = tdata[63:56];
      got.payload_length = tdata[71:64];
      got.error_code     = tdata[74:72];
      if (expected_results.size() == 0) begin
         if (count_mismatch())
            $display("Mismatch: unexpected result kind %0d data %02h err %0d",
                     got.kind, got.data_byte, got.error_code);
         return;
      end
      want = expected_results.pop_front();
      case (want.kind)
         KIND_DATA:   data_seen++;
         KIND_ACCEPT: accepts_seen++;
         default:     rejects_seen++;
      endcase
      if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
          got.meter_address !== want.meter_address ||
          got.control_code !== want.control_code ||
          got.payload_length !== want.payload_length ||
          got.error_code !== want.error_code) begin
         if (count_mismatch())
            $display({"Mismatch: expected kind %0d data %02h addr %012h ctrl %02h",
                      " len %02h err %0d; got kind %0d data %02h addr %012h",
                      " ctrl %02h len %02h err %0d"},
                     want.kind, want.data_byte, want.meter_address,
                     want.control_code, want.payload_length, want.error_code,
                     got.kind, got.data_byte, got.meter_address,
                     got.control_code, got.payload_length, got.error_code);
      end
   endfunction

   function void check_register(logic [1:0] index, logic [7:0] want, logic [7:0] got);
      if (got !== want && count_mismatch())
         $display("Mismatch: register %0d read %02h, expected %02h", index, got, want);
   endfunction

   // Any expectation still queued at the end is a missing result.
   function void check_leftovers();
      parse_result_type want;
      while (expected_results.size() != 0) begin
         want = expected_results.pop_front();
         if (count_mismatch())
            $display("Mismatch: missing result kind %0d data %02h err %0d",
                     want.kind, want.data_byte, want.error_code);
      end
   endfunction
endclass

module meter_frame_parser_tb;

   // Ways in which a generated buffer departs from a well-formed frame.
   typedef enum int {
      FLAW_NONE,
      FLAW_START2,
      FLAW_CSUM,
      FLAW_END,
      FLAW_TRUNC,
      FLAW_TAIL,
      FLAW_NOISE
   } flaw_type;

   localparam int LONG_HOLD   = 300;
   localparam int SETTLE      = 4;
   localparam int PHASE_BYTES = 275;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;
   logic        req_tlast   = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [79:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [3:0]  csr_paddr   = 4'h0;
   logic [31:0] csr_pwdata  = 32'h0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   frame_scoreboard frames = new;
   logic [7:0]      frame_bytes[$];
   int              send_idle_pct = 0;
   int              recv_idle_pct = 0;
   int              hold_requests = 0;
   int              buffer_count  = 0;

   meter_frame_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Both channels are observed at the clock edge, input first.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) frames.note_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) frames.check_result(rsp_tdata, rsp_tuser);
      end
   end

   // Result receiver: random stalls, plus a long hold-off on request.
   initial begin : receiver
      int hold_served;
      hold_served = 0;
      forever begin
         @(posedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Adds one byte at the end of the buffer under construction.
   function void append_byte(logic [7:0] value);
      frame_bytes.insert(frame_bytes.size(), value);
   endfunction

   // Offers one byte, with random idle cycles first, and waits for its transaction.
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_buffer();
      buffer_count++;
      foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
   endtask

   // Waits until every expected result has come and the block has settled.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (frames.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register write followed by a read-back of the same register.
   task automatic csr_write(input logic [1:0] index, input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= {24'h0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      frames.set_register(index, value);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      frames.check_register(index, value, csr_prdata[7:0]);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Builds one buffer: preamble, frame with the given payload length, and
   // the requested flaw. Noise buffers are random bytes with no structure.
   task automatic build_frame(input int pre_len, input int len, input flaw_type flaw);
      logic [7:0] b;
      logic [7:0] sum;
      int         cut;
      frame_bytes.delete();
      if (flaw == FLAW_NOISE) begin
         repeat ($urandom_range(1, 6)) append_byte(8'($urandom));
         return;
      end
      repeat (pre_len) begin
         b = 8'($urandom);
         if (b == frames.start_marker) b = ~b;
         append_byte(b);
      end
      sum = frames.start_marker;
      append_byte(frames.start_marker);
      repeat (ADDR_BYTES) begin
         b = 8'($urandom);
         append_byte(b);
         sum = sum + b;
      end
      if (flaw == FLAW_START2)
         append_byte(frames.start_marker ^ (8'h01 << $urandom_range(7)));
      else
         append_byte(frames.start_marker);
      sum = sum + frames.start_marker;
      b = 8'($urandom);
      append_byte(b);
      sum = sum + b + 8'(len);
      append_byte(8'(len));
      repeat (len) begin
         b = 8'($urandom);
         append_byte(b);
         sum = sum + b;
      end
      if (flaw == FLAW_CSUM) sum = sum ^ 8'($urandom_range(1, 255));
      append_byte(sum);
      if (flaw == FLAW_END)
         append_byte(frames.end_marker ^ 8'($urandom_range(1, 255)));
      else
         append_byte(frames.end_marker);
      if (flaw == FLAW_TAIL)
         repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
      if (flaw == FLAW_TRUNC) begin
         cut = $urandom_range(0, frame_bytes.size() - 2);
         while (frame_bytes.size() > cut + 1) void'(frame_bytes.pop_back());
      end
   endtask

   // Main stimulus: directed buffers, then four register settings of random
   // buffers under three idle patterns.
   initial begin : stimulus
      int       pick;
      int       len;
      flaw_type flaw;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 29;
      recv_idle_pct = 73;

      // Lone bytes: no start at both byte extremes, then a start that ends the buffer.
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(frames.start_marker, 1'b1);
      // Zero-length frame, then a frame cut off on its only data byte.
      build_frame(0, 0, FLAW_NONE);
      send_buffer();
      build_frame(0, 1, FLAW_NONE);
      void'(frame_bytes.pop_back());
      void'(frame_bytes.pop_back());
      send_buffer();

      for (int setting = 0; setting < 4; setting++) begin
         drain();
         case (setting)
            1: begin
               csr_write(REG_START_MARKER, 8'h00);
               csr_write(REG_END_MARKER, 8'hFF);
               csr_write(REG_DATA_OFFSET, 8'hFF);
            end
            2: begin
               csr_write(REG_START_MARKER, 8'hFF);
               csr_write(REG_END_MARKER, 8'h00);
               csr_write(REG_DATA_OFFSET, 8'h00);
            end
            3: begin
               csr_write(REG_START_MARKER, 8'($urandom));
               csr_write(REG_END_MARKER, 8'($urandom));
               csr_write(REG_DATA_OFFSET, 8'($urandom));
            end
            default: ;
         endcase
         send_idle_pct = (setting == 0) ? 29 : (setting == 1) ? 73 : 0;
         recv_idle_pct = (setting == 0) ? 73 : (setting == 1) ? 29 : 0;

         // Longest frame against a long receiver hold-off, then a full pause.
         if (setting == 2) begin
            hold_requests++;
            build_frame(1, 255, FLAW_NONE);
            send_buffer();
            drain();
         end

         while (frames.bytes_seen < (setting + 1) * PHASE_BYTES) begin
            pick = $urandom_range(99);
            len  = ($urandom_range(39) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 8);
            flaw = (pick < 62) ? FLAW_NONE   :
                   (pick < 68) ? FLAW_START2 :
                   (pick < 76) ? FLAW_CSUM   :
                   (pick < 83) ? FLAW_END    :
                   (pick < 91) ? FLAW_TRUNC  :
                   (pick < 96) ? FLAW_TAIL   : FLAW_NOISE;
            build_frame($urandom_range(0, 3), len, flaw);
            send_buffer();
         end
      end

      drain();
      repeat (20) @(posedge clock);
      frames.check_leftovers();
      $display("Summary: %0d bytes in %0d buffers over four register settings,",
               frames.bytes_seen, buffer_count);
      $display("  %0d data bytes, %0d accepted and %0d rejected frames; %0d mismatches.",
               frames.data_seen, frames.accepts_seen, frames.rejects_seen,
               frames.mismatches);
      if (frames.mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin : watchdog
      #1000000;
      $display("Timeout: stimulus did not complete.");
      $display("*** FAILED ***");
      $finish;
   end

endmodule
